[src/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/owtsm_pkg.sv]
// Shared types and constants for the 1-Wire bus master.
// No dependencies.
package owtsm_pkg;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_BUS_RESET = 3'd1;
  localparam logic [2:0] MODE_WRITE     = 3'd2;
  localparam logic [2:0] MODE_READ      = 3'd3;
  localparam logic [2:0] MODE_CONVERT   = 3'd4;
  localparam logic [2:0] MODE_READ_TEMP = 3'd5;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
  localparam logic [1:0] ST_REJECTED    = 2'd2;

  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT_T  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD   = 8'hBE;

  localparam int         TIMER_W        = 9;
  localparam logic [8:0] T_RESET_LOW    = 9'd480;
  localparam logic [8:0] T_PRESENCE     = 9'd70;
  localparam logic [8:0] T_RESET_END    = 9'd480;
  localparam logic [8:0] T_SLOT         = 9'd70;
  localparam logic [8:0] T_W1_LOW       = 9'd6;
  localparam logic [8:0] T_W0_LOW       = 9'd60;
  localparam logic [8:0] T_R_LOW        = 9'd6;
  localparam logic [8:0] T_R_SAMPLE     = 9'd15;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_CMD,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       line_sample;
  } item_t;

endpackage

[src/one_wire_temp_sensor_master.sv]
// 1-Wire bus master: one result word per input word (tick, command or other mode).
// Path: the word enters the queue at its accepting edge and the sequencer
// result register loads from the queue head when the output is not stalled.
// Throughput: one word per cycle unless the output stalls; a two-entry queue
// between front and sequencer stalls the input only when both entries are held.
// Reset (rst_n low, synchronous): queue empty, sequencer idle, result register empty.
`include "assert_macros.svh"

module one_wire_temp_sensor_master (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [7:0]         in_write_data,
  input  logic               in_line_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_drive_low,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [1:0]         out_status,
  output logic [7:0]         out_read_data,
  output logic signed [15:0] out_temperature_raw
);
  import owtsm_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  owtsm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_write_data  (in_write_data),
    .in_line_sample (in_line_sample),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  owtsm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_item              (q_item),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive_low       (out_drive_low),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_status          (out_status),
    .out_read_data       (out_read_data),
    .out_temperature_raw (out_temperature_raw)
  );

  // a full queue always has a word for the sequencer
  `ASSERT_IMPL(a_stall_has_word, in_stall, q_valid, "input stalled with empty queue")
  // a word taken from the queue always lands in the result register
  `ASSERT_NEXT(a_pop_loads_out, q_pop, out_valid, "popped word lost before output")
  // finishing word ends the busy period
  `ASSERT_IMPL(a_done_not_busy, out_valid && out_done_res, !out_busy_res,
               "done word reports busy")
  // data fields only carry values on a finishing word
  `ASSERT_IMPL(a_data_only_on_done, out_valid && !out_done_res,
               out_read_data == 8'd0 && out_temperature_raw == 16'sd0,
               "data on a word without done")

endmodule

[src/owtsm_front.sv]
// Front end: takes input words, classifies them and holds them in a
// two-entry queue for the sequencer. Depends on owtsm_pkg.
module owtsm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_mode,
  input  logic [7:0]        in_write_data,
  input  logic              in_line_sample,
  output owtsm_pkg::item_t  q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import owtsm_pkg::*;

  localparam int QDEPTH = 2;

  item_t      slot_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  item_t      cls_item;
  logic       push;

  always_comb begin
    cls_item.mode        = in_mode;
    cls_item.write_data  = in_write_data;
    cls_item.line_sample = in_line_sample;
    if (in_mode == MODE_TICK) begin
      cls_item.kind = KIND_TICK;
    end else if (in_mode <= MODE_READ_TEMP) begin
      cls_item.kind = KIND_CMD;
    end else begin
      cls_item.kind = KIND_NONE;
    end
  end

  assign in_stall = (count_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

[src/owtsm_back.sv]
// Back end: bus sequencer (reset pulse, write and read slots, command
// chains) with a registered result stage. Depends on owtsm_pkg.
module owtsm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  owtsm_pkg::item_t   q_item,
  input  logic               q_valid,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_drive_low,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [1:0]         out_status,
  output logic [7:0]         out_read_data,
  output logic signed [15:0] out_temperature_raw
);
  import owtsm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_WBIT,
    PH_RBIT
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [TIMER_W-1:0]   slot_r, slot_nxt, t_inc;
  logic [2:0]           bit_r, bit_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [7:0]           low_r, low_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic                 pres_r, pres_nxt;

  logic                 valid_r;
  logic                 drive_r, busy_r, done_r;
  logic [1:0]           status_r;
  logic [7:0]           read_r;
  logic [15:0]          temp_r;

  logic                 busy, fin, bdone;
  logic                 o_drive, o_busy, o_done;
  logic [1:0]           o_status;
  logic [7:0]           o_read;
  logic [15:0]          o_temp;

  function automatic logic drive_level(phase_t ph, logic [TIMER_W-1:0] t, logic b0);
    logic lvl;
    lvl = 1'b0;
    case (ph)
      PH_RST_LOW: lvl = 1'b1;
      PH_WBIT:    lvl = (t < (b0 ? T_W1_LOW : T_W0_LOW));
      PH_RBIT:    lvl = (t < T_R_LOW);
      default:    lvl = 1'b0;
    endcase
    return lvl;
  endfunction

  assign busy  = (phase_r != PH_IDLE);
  assign q_pop = q_valid && (!valid_r || !out_stall);
  assign t_inc = slot_r + 9'd1;

  always_comb begin
    phase_nxt = phase_r;
    slot_nxt  = slot_r;
    bit_nxt   = bit_r;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    low_nxt   = low_r;
    cmd_nxt   = cmd_r;
    pres_nxt  = pres_r;
    fin       = 1'b0;
    bdone     = 1'b0;
    o_drive   = 1'b0;
    o_busy    = 1'b0;
    o_done    = 1'b0;
    o_status  = ST_OK;
    o_read    = 8'd0;
    o_temp    = 16'd0;

    unique case (q_item.kind)
      KIND_TICK: begin
        if (busy) begin
          slot_nxt = t_inc;
          case (phase_r)
            PH_RST_LOW: begin
              if (t_inc >= T_RESET_LOW) begin
                phase_nxt = PH_RST_WAIT;
                slot_nxt  = '0;
              end
            end
            PH_RST_WAIT: begin
              if (t_inc == T_PRESENCE) begin
                pres_nxt = ~q_item.line_sample;
              end
              if (t_inc >= T_RESET_END) begin
                if (!pres_nxt) begin
                  fin      = 1'b1;
                  o_status = ST_NO_PRESENCE;
                end else if (cmd_r == MODE_BUS_RESET) begin
                  fin = 1'b1;
                end else begin
                  step_nxt  = 3'd1;
                  shift_nxt = CMD_SKIP_ROM;
                  bit_nxt   = 3'd0;
                  slot_nxt  = '0;
                  phase_nxt = PH_WBIT;
                end
              end
            end
            PH_WBIT: begin
              if (t_inc >= T_SLOT) begin
                shift_nxt = shift_r >> 1;
                bit_nxt   = bit_r + 3'd1;
                slot_nxt  = '0;
                bdone     = (bit_r == 3'd7);
              end
            end
            PH_RBIT: begin
              if (t_inc == T_R_SAMPLE) begin
                shift_nxt = {q_item.line_sample, shift_r[7:1]};
              end
              if (t_inc >= T_SLOT) begin
                bit_nxt  = bit_r + 3'd1;
                slot_nxt = '0;
                bdone    = (bit_r == 3'd7);
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              slot_nxt  = '0;
            end
          endcase

          // end of a byte: chain to the next byte of the command or finish
          if (bdone) begin
            case (cmd_r)
              MODE_READ: begin
                fin    = 1'b1;
                o_read = shift_nxt;
              end
              MODE_CONVERT: begin
                if (step_r == 3'd1) begin
                  step_nxt  = 3'd2;
                  shift_nxt = CMD_CONVERT_T;
                  phase_nxt = PH_WBIT;
                end else begin
                  fin = 1'b1;
                end
              end
              MODE_READ_TEMP: begin
                if (step_r == 3'd1) begin
                  step_nxt  = 3'd2;
                  shift_nxt = CMD_READ_PAD;
                  phase_nxt = PH_WBIT;
                end else if (step_r == 3'd2) begin
                  step_nxt  = 3'd3;
                  shift_nxt = 8'd0;
                  phase_nxt = PH_RBIT;
                end else if (step_r == 3'd3) begin
                  low_nxt   = shift_nxt;
                  step_nxt  = 3'd4;
                  shift_nxt = 8'd0;
                  phase_nxt = PH_RBIT;
                end else begin
                  fin    = 1'b1;
                  o_temp = {shift_nxt, low_r};
                end
              end
              default: fin = 1'b1;
            endcase
          end

          if (fin) begin
            phase_nxt = PH_IDLE;
            slot_nxt  = '0;
            o_done    = 1'b1;
          end else begin
            o_drive = drive_level(phase_nxt, slot_nxt, shift_nxt[0]);
            o_busy  = 1'b1;
          end
        end
      end
      KIND_CMD: begin
        if (busy) begin
          o_drive  = drive_level(phase_r, slot_r, shift_r[0]);
          o_busy   = 1'b1;
          o_status = ST_REJECTED;
        end else begin
          cmd_nxt  = q_item.mode;
          step_nxt = 3'd0;
          pres_nxt = 1'b0;
          bit_nxt  = 3'd0;
          slot_nxt = '0;
          if (q_item.mode == MODE_WRITE) begin
            shift_nxt = q_item.write_data;
            phase_nxt = PH_WBIT;
          end else if (q_item.mode == MODE_READ) begin
            shift_nxt = 8'd0;
            phase_nxt = PH_RBIT;
          end else begin
            phase_nxt = PH_RST_LOW;
          end
          o_drive = drive_level(phase_nxt, slot_nxt, shift_nxt[0]);
          o_busy  = 1'b1;
        end
      end
      default: begin
        o_drive = drive_level(phase_r, slot_r, shift_r[0]);
        o_busy  = busy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      slot_r  <= '0;
      bit_r   <= 3'd0;
      step_r  <= 3'd0;
      shift_r <= 8'd0;
      low_r   <= 8'd0;
      cmd_r   <= 3'd0;
      pres_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r  <= phase_nxt;
        slot_r   <= slot_nxt;
        bit_r    <= bit_nxt;
        step_r   <= step_nxt;
        shift_r  <= shift_nxt;
        low_r    <= low_nxt;
        cmd_r    <= cmd_nxt;
        pres_r   <= pres_nxt;
        valid_r  <= 1'b1;
        drive_r  <= o_drive;
        busy_r   <= o_busy;
        done_r   <= o_done;
        status_r <= o_status;
        read_r   <= o_read;
        temp_r   <= o_temp;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = valid_r;
  assign out_drive_low       = drive_r;
  assign out_busy_res        = busy_r;
  assign out_done_res        = done_r;
  assign out_status          = status_r;
  assign out_read_data       = read_r;
  assign out_temperature_raw = signed'(temp_r);

endmodule
